>>> rtl/core/qap_pkg.sv
// Shared types, constants and tables of the quaternion attitude propagator.
package qap_pkg;

  localparam int QUAT_WIDTH_DEF = 32;
  localparam int RATE_W         = 16;
  localparam int STEP_W         = 24;
  localparam int OUT_W          = 32;
  localparam int CFG_IDX_W      = 8;
  localparam int CFG_DATA_W     = 24;
  localparam int H_SHIFT        = 37;

  localparam logic [CFG_IDX_W-1:0] REG_BIAS_X    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_Z    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 8'd3;

  localparam logic signed [RATE_W-1:0] BIAS_X_RST    = 16'sd2048;
  localparam logic signed [RATE_W-1:0] BIAS_Y_RST    = 16'sd0;
  localparam logic signed [RATE_W-1:0] BIAS_Z_RST    = 16'sd0;
  localparam logic        [STEP_W-1:0] STEP_TIME_RST = 24'd167772;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_H,
    SH_Q
  } shift_e;

  typedef struct packed {
    logic   start;
    shift_e sh;
  } mul_req_t;

  typedef struct packed {
    logic [1:0] hi;
    logic [1:0] qi;
    logic       neg;
  } term_t;

  function automatic term_t term_sel(input logic [1:0] comp, input logic [1:0] k);
    term_t t;
    t = '{hi: 2'd0, qi: 2'd0, neg: 1'b0};
    case ({comp, k})
      4'h0: t = '{hi: 2'd0, qi: 2'd1, neg: 1'b1};
      4'h1: t = '{hi: 2'd1, qi: 2'd2, neg: 1'b1};
      4'h2: t = '{hi: 2'd2, qi: 2'd3, neg: 1'b1};
      4'h4: t = '{hi: 2'd0, qi: 2'd0, neg: 1'b0};
      4'h5: t = '{hi: 2'd2, qi: 2'd2, neg: 1'b0};
      4'h6: t = '{hi: 2'd1, qi: 2'd3, neg: 1'b1};
      4'h8: t = '{hi: 2'd1, qi: 2'd0, neg: 1'b0};
      4'h9: t = '{hi: 2'd2, qi: 2'd1, neg: 1'b1};
      4'hA: t = '{hi: 2'd0, qi: 2'd3, neg: 1'b0};
      4'hC: t = '{hi: 2'd2, qi: 2'd0, neg: 1'b0};
      4'hD: t = '{hi: 2'd1, qi: 2'd1, neg: 1'b0};
      4'hE: t = '{hi: 2'd0, qi: 2'd2, neg: 1'b1};
      default: t = '{hi: 2'd0, qi: 2'd0, neg: 1'b0};
    endcase
    return t;
  endfunction

endpackage

>>> rtl/core/qap_if.sv
// Channel interfaces: gyro rate words, quaternion words, configuration writes.
interface qap_rate_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [qap_pkg::RATE_W-1:0]        rate_x;
  logic signed [qap_pkg::RATE_W-1:0]        rate_y;
  logic signed [qap_pkg::RATE_W-1:0]        rate_z;
  modport source (output valid, rate_x, rate_y, rate_z, input ready);
  modport sink (input valid, rate_x, rate_y, rate_z, output ready);
endinterface

interface qap_quat_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [qap_pkg::OUT_W-1:0]         quat_w;
  logic signed [qap_pkg::OUT_W-1:0]         quat_x;
  logic signed [qap_pkg::OUT_W-1:0]         quat_y;
  logic signed [qap_pkg::OUT_W-1:0]         quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qap_cfg_if;
  logic                                     valid;
  logic                                     ready;
  logic [qap_pkg::CFG_IDX_W-1:0]            index;
  logic [qap_pkg::CFG_DATA_W-1:0]           data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/qap_mul.sv
// Shared shift-add multiplier with rounded right shift, one multiplier bit per cycle.
module qap_mul #(
  parameter int MW = 42,
  parameter int QF = 30
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  qap_pkg::mul_req_t      req_i,
  input  logic signed [MW-1:0]   a_i,
  input  logic signed [MW-1:0]   b_i,
  output logic                   done_o,
  output logic signed [MW-1:0]   res_o
);

  localparam int CW = $clog2(MW + 1);

  logic                   busy_q, fin_q, done_q, neg_q;
  logic [CW-1:0]          cnt_q;
  logic [MW-1:0]          ma_q;
  logic [2*MW-1:0]        prod_q;
  qap_pkg::shift_e        sh_q;
  logic signed [MW-1:0]   res_q;
  logic [MW:0]            sum;
  logic [2*MW-1:0]        rnd;

  assign sum = {1'b0, prod_q[2*MW-1:MW]} + (prod_q[0] ? {1'b0, ma_q} : {(MW+1){1'b0}});

  always_comb begin
    case (sh_q)
      qap_pkg::SH_H: rnd = (prod_q + ((2*MW)'(1) << (qap_pkg::H_SHIFT - 1)))
                           >> qap_pkg::H_SHIFT;
      qap_pkg::SH_Q: rnd = (prod_q + ((2*MW)'(1) << (QF - 1))) >> QF;
      default:       rnd = prod_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      sh_q   <= qap_pkg::SH_NONE;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        neg_q  <= a_i[MW-1] ^ b_i[MW-1];
        ma_q   <= a_i[MW-1] ? MW'(-a_i) : MW'(a_i);
        prod_q <= {{MW{1'b0}}, (b_i[MW-1] ? MW'(-b_i) : MW'(b_i))};
        sh_q   <= req_i.sh;
        cnt_q  <= CW'(MW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        prod_q <= {sum, prod_q[MW-1:1]};
        cnt_q  <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        res_q  <= neg_q ? -$signed(MW'(rnd)) : $signed(MW'(rnd));
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> rtl/core/quaternion_attitude_propagator.sv
// Top level: gyro bias removal, Euler quaternion step and renormalization.
//
//   channel   dir   handshake          payload
//   cfg_i     in    valid/ready        index, data (bias_x, bias_y, bias_z, step_time)
//   rate_i    in    valid/ready        rate_x, rate_y, rate_z (Q4.12)
//   quat_o    out   valid/ready        quat_w, quat_x, quat_y, quat_z (Q2.30)
//
// One word takes (3 + 12 + 4 + 2*(QW-1) + 4) multiplies, each in turn an issue,
// MW shift-add steps, a round and an accumulate; all work runs through one
// bit-serial multiplier, MW = max(42, QW + 5).
// rate_i is ready only while idle; a result waiting on quat_o does not block it.
// A finished word holds until quat_o frees. Reset loads the identity attitude.
module quaternion_attitude_propagator #(
  parameter int QUAT_WIDTH = qap_pkg::QUAT_WIDTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  qap_cfg_if.sink    cfg_i,
  qap_rate_if.sink   rate_i,
  qap_quat_if.source quat_o
);

  localparam int W   = QUAT_WIDTH;
  localparam int QF  = W - 2;
  localparam int MW  = (W + 5 > 42) ? W + 5 : 42;
  localparam int AW  = MW + 2;
  localparam int BW  = $clog2(QF + 1);
  localparam int LS  = (W < 32) ? 32 - W : 0;
  localparam int RD  = (W > 32) ? W - 32 : 1;
  localparam int WR  = qap_pkg::RATE_W + 1;

  localparam logic signed [AW-1:0] QMAX_A = (AW'(1) << (W - 1)) - AW'(1);
  localparam logic signed [AW-1:0] QMIN_A = -(AW'(1) << (W - 1));
  localparam logic signed [MW-1:0] QONE_M = MW'(1) << QF;
  localparam logic signed [W-1:0]  QONE_W = W'(1) << QF;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_FIN} state_e;
  typedef enum logic [2:0] {PH_H, PH_N, PH_NRM, PH_GT, PH_GR, PH_OUT} phase_e;

  state_e state_q;
  phase_e ph_q;

  logic signed [qap_pkg::RATE_W-1:0] bias_q [3];
  logic        [qap_pkg::STEP_W-1:0] step_q;
  logic signed [W-1:0]               att_q  [4];
  logic signed [WR-1:0]              w_q    [3];
  logic signed [MW-1:0]              h_q    [3];
  logic signed [W-1:0]               n_q    [4];
  logic signed [AW-1:0]              acc_q;
  logic signed [MW-1:0]              nrm_q, t_q;
  logic signed [W-1:0]               g_q;
  logic [1:0]                        j_q, k_q;
  logic [BW-1:0]                     bit_q;
  logic                              out_valid_q;
  logic signed [qap_pkg::OUT_W-1:0]  out_q  [4];

  qap_pkg::mul_req_t   req;
  qap_pkg::term_t      term;
  logic signed [MW-1:0] op_a, op_b, res;
  logic                 done;
  logic signed [W-1:0]  cand;
  logic signed [AW-1:0] acc_sum;

  function automatic logic signed [W-1:0] sat_w(input logic signed [AW-1:0] v);
    if (v > QMAX_A) return W'(QMAX_A);
    if (v < QMIN_A) return W'(QMIN_A);
    return W'(v);
  endfunction

  function automatic logic signed [qap_pkg::OUT_W-1:0] to_q30(input logic signed [W-1:0] v);
    logic signed [63:0] e;
    logic        [63:0] m, r;
    e = 64'(v);
    if (W > 32) begin
      m = e[63] ? 64'(-e) : 64'(e);
      r = (m + (64'(1) << (RD - 1))) >> RD;
      if (!e[63] && r > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (e[63] && r > 64'h8000_0000) return 32'sh8000_0000;
      if (e[63]) return 32'(-$signed(r));
      return 32'(r);
    end
    return 32'(e <<< LS);
  endfunction

  assign term    = qap_pkg::term_sel(j_q, k_q);
  assign cand    = g_q | (W'(1) << bit_q);
  assign acc_sum = acc_q + (term.neg ? -AW'(res) : AW'(res));

  always_comb begin
    op_a = '0;
    op_b = '0;
    req.sh = qap_pkg::SH_Q;
    unique case (ph_q)
      PH_H: begin
        op_a = MW'(w_q[j_q]);
        op_b = $signed(MW'(step_q));
        req.sh = qap_pkg::SH_NONE;
      end
      PH_N: begin
        op_a = h_q[term.hi];
        op_b = MW'(att_q[term.qi]);
        req.sh = qap_pkg::SH_H;
      end
      PH_NRM: begin
        op_a = MW'(n_q[j_q]);
        op_b = MW'(n_q[j_q]);
      end
      PH_GT: begin
        op_a = MW'(cand);
        op_b = MW'(cand);
      end
      PH_GR: begin
        op_a = t_q;
        op_b = nrm_q;
      end
      PH_OUT: begin
        op_a = MW'(n_q[j_q]);
        op_b = MW'(g_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    req.start = (state_q == ST_ISSUE);
  end

  qap_mul #(.MW(MW), .QF(QF)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (op_a),
    .b_i    (op_b),
    .done_o (done),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_H;
      bias_q[0]   <= qap_pkg::BIAS_X_RST;
      bias_q[1]   <= qap_pkg::BIAS_Y_RST;
      bias_q[2]   <= qap_pkg::BIAS_Z_RST;
      step_q      <= qap_pkg::STEP_TIME_RST;
      att_q[0]    <= QONE_W;
      att_q[1]    <= '0;
      att_q[2]    <= '0;
      att_q[3]    <= '0;
      j_q         <= '0;
      k_q         <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          qap_pkg::REG_BIAS_X:    bias_q[0] <= $signed(cfg_i.data[qap_pkg::RATE_W-1:0]);
          qap_pkg::REG_BIAS_Y:    bias_q[1] <= $signed(cfg_i.data[qap_pkg::RATE_W-1:0]);
          qap_pkg::REG_BIAS_Z:    bias_q[2] <= $signed(cfg_i.data[qap_pkg::RATE_W-1:0]);
          qap_pkg::REG_STEP_TIME: step_q    <= cfg_i.data;
          default: ;
        endcase
      end
      if (out_valid_q && quat_o.ready && state_q != ST_FIN) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (rate_i.valid) begin
            w_q[0]  <= WR'(rate_i.rate_x) - WR'(bias_q[0]);
            w_q[1]  <= WR'(rate_i.rate_y) - WR'(bias_q[1]);
            w_q[2]  <= WR'(rate_i.rate_z) - WR'(bias_q[2]);
            acc_q   <= AW'(att_q[0]);
            j_q     <= '0;
            k_q     <= '0;
            ph_q    <= PH_H;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (done) begin
            if (!(ph_q == PH_OUT && j_q == 2'd3)) state_q <= ST_ISSUE;
            unique case (ph_q)
              PH_H: begin
                h_q[j_q] <= res;
                if (j_q == 2'd2) begin
                  j_q  <= '0;
                  ph_q <= PH_N;
                end else begin
                  j_q <= j_q + 2'd1;
                end
              end
              PH_N: begin
                if (k_q == 2'd2) begin
                  n_q[j_q] <= sat_w(acc_sum);
                  k_q      <= '0;
                  if (j_q == 2'd3) begin
                    j_q   <= '0;
                    nrm_q <= '0;
                    ph_q  <= PH_NRM;
                  end else begin
                    j_q   <= j_q + 2'd1;
                    acc_q <= AW'(att_q[j_q + 2'd1]);
                  end
                end else begin
                  k_q   <= k_q + 2'd1;
                  acc_q <= acc_sum;
                end
              end
              PH_NRM: begin
                nrm_q <= nrm_q + res;
                if (j_q == 2'd3) begin
                  j_q   <= '0;
                  g_q   <= '0;
                  bit_q <= BW'(QF);
                  ph_q  <= PH_GT;
                end else begin
                  j_q <= j_q + 2'd1;
                end
              end
              PH_GT: begin
                t_q  <= res;
                ph_q <= PH_GR;
              end
              PH_GR: begin
                if (res <= QONE_M) g_q <= cand;
                if (bit_q == '0) begin
                  j_q  <= '0;
                  ph_q <= PH_OUT;
                end else begin
                  bit_q <= bit_q - BW'(1);
                  ph_q  <= PH_GT;
                end
              end
              PH_OUT: begin
                att_q[j_q] <= sat_w(AW'(res));
                if (j_q == 2'd3) begin
                  state_q <= ST_FIN;
                end else begin
                  j_q <= j_q + 2'd1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_FIN: begin
          if (!out_valid_q || quat_o.ready) begin
            out_q[0]    <= to_q30(att_q[0]);
            out_q[1]    <= to_q30(att_q[1]);
            out_q[2]    <= to_q30(att_q[2]);
            out_q[3]    <= to_q30(att_q[3]);
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign cfg_i.ready  = 1'b1;
  assign rate_i.ready = (state_q == ST_IDLE);
  assign quat_o.valid = out_valid_q;
  assign quat_o.quat_w = out_q[0];
  assign quat_o.quat_x = out_q[1];
  assign quat_o.quat_y = out_q[2];
  assign quat_o.quat_z = out_q[3];

endmodule

>>> rtl/core/qap_checker.sv
// Port-level assertions of the quaternion attitude propagator and their bind.
module qap_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_w_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_w_i))
    else $error("stalled quaternion word changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("rate word taken while a step is running");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a step");

endmodule

bind quaternion_attitude_propagator qap_checker u_qap_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (rate_i.valid),
  .in_ready_i  (rate_i.ready),
  .out_valid_i (quat_o.valid),
  .out_ready_i (quat_o.ready),
  .out_w_i     (quat_o.quat_w)
);
